/* hw/rtl/swtc_pkg.sv */
`default_nettype none

package swtc_pkg;

  // Default sizes
  localparam int DEF_SEND_SLOTS    = 64;
  localparam int DEF_REORDER_SLOTS = 32;
  localparam int DEF_MAX_SEG_BYTES = 1012;

  // Field widths
  localparam int SEQ_W     = 16;
  localparam int LEN_W     = 10;
  localparam int WIN_W     = 16;
  localparam int SLOT_W    = 6;
  localparam int RX_SLOT_W = 5;
  localparam int TICK_W    = 32;
  localparam int DUP_W     = 8;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Register reset values
  localparam logic              RST_START_ROLE = 1'b0;
  localparam logic [SEQ_W-1:0]  RST_INIT_SEQ   = 16'd100;
  localparam logic [WIN_W-1:0]  RST_MAX_RWIN   = 16'd40480;
  localparam logic [WIN_W-1:0]  RST_PEER_WIN   = 16'd1012;
  localparam logic [TICK_W-1:0] RST_TIMEOUT    = 32'd1000;
  localparam logic [DUP_W-1:0]  RST_DUP_LIMIT  = 8'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RWIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_WIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_LIMIT  = 3'd5;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_SYN     = 3'd1,
    KIND_SYNACK  = 3'd2,
    KIND_ACK     = 3'd3,
    KIND_DATA    = 3'd4,
    KIND_RETX    = 3'd5,
    KIND_DELIVER = 3'd6,
    KIND_DROP    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    PH_CLIENT_START = 3'd0,
    PH_CLIENT_AWAIT = 3'd1,
    PH_SERVER_START = 3'd2,
    PH_SERVER_AWAIT = 3'd3,
    PH_NORMAL       = 3'd4
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic              syn;
    logic              ack_flag;
    logic [LEN_W-1:0]  len;
    logic [WIN_W-1:0]  win;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } res_t;

  function automatic res_t mk_res(kind_t k, logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack,
                                  logic syn, logic ackf, logic [LEN_W-1:0] len,
                                  logic [WIN_W-1:0] win, logic [SLOT_W-1:0] slot,
                                  logic last);
    res_t r;
    r.kind     = k;
    r.seq      = seq;
    r.ack      = ack;
    r.syn      = syn;
    r.ack_flag = ackf;
    r.len      = len;
    r.win      = win;
    r.slot     = slot;
    r.last     = last;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sliding_window_transport_control.sv */
// Sliding-window transport control plane.
// Input channel (in_valid/in_ready): one item per command: received packet,
// poll for a packet to send, or timer tick. Result channel (out_valid/
// out_ready): zero or more result items per input item; out_last marks the
// final result of an item. Configuration: cfg_we/cfg_index/cfg_data; the
// user must write it only while the block is idle; the block does not
// enforce this. One item is worked on at a time. A poll, a tick with nothing
// outstanding, or a packet in a handshake phase is handled in the idle
// state; its result passes through the staging register, then the output
// register. A packet carrying a new ACK scans every slot of the send table.
// An in-order payload scans the reorder table once per delivered segment
// plus one final pass; an out-of-order payload takes at most one pass. A
// retransmit tick scans the send table for the oldest entry. Both tables
// are single-port memories with a registered read, so each slot is read,
// then compared. Reset clears all control state and marks every table entry
// invalid at once; no clearing pass is needed. When the receiver stalls, the
// output register holds its item and one more result waits in a staging
// register; a scan with a result to emit pauses until that stage drains.
`default_nettype none

module sliding_window_transport_control
  import swtc_pkg::*;
#(
  parameter int SEND_SLOTS        = DEF_SEND_SLOTS,
  parameter int REORDER_SLOTS     = DEF_REORDER_SLOTS,
  parameter int MAX_SEGMENT_BYTES = DEF_MAX_SEG_BYTES
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [1:0]            in_cmd,
  input  wire  [SEQ_W-1:0]      in_rx_seq,
  input  wire  [SEQ_W-1:0]      in_rx_ack,
  input  wire  [LEN_W-1:0]      in_rx_length,
  input  wire  [WIN_W-1:0]      in_rx_window,
  input  wire                   in_rx_syn,
  input  wire                   in_rx_ack_flag,
  input  wire  [RX_SLOT_W-1:0]  in_rx_slot,
  input  wire  [LEN_W-1:0]      in_app_bytes,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [2:0]            out_kind,
  output logic [SEQ_W-1:0]      out_seq,
  output logic [SEQ_W-1:0]      out_ack,
  output logic                  out_syn,
  output logic                  out_ack_flag,
  output logic [LEN_W-1:0]      out_length,
  output logic [WIN_W-1:0]      out_window,
  output logic [SLOT_W-1:0]     out_slot,
  output logic                  out_last,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_W-1:0]      cfg_data
);

  localparam int SW = $clog2(SEND_SLOTS);
  localparam int RW = $clog2(REORDER_SLOTS);
  localparam int CW = (SW > RW) ? SW : RW;
  localparam logic [CW-1:0] SEND_LAST = CW'(SEND_SLOTS - 1);
  localparam logic [CW-1:0] RO_LAST   = CW'(REORDER_SLOTS - 1);
  localparam logic [WIN_W-1:0] MAX_SEG = WIN_W'(MAX_SEGMENT_BYTES);

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } snd_ent_t;

  typedef struct packed {
    logic [SEQ_W-1:0]     seq;
    logic [LEN_W-1:0]     len;
    logic [RX_SLOT_W-1:0] slot;
  } ro_ent_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_ACKSCAN = 7'b0000010,
    ST_PAYLOAD = 7'b0000100,
    ST_ROSCAN  = 7'b0001000,
    ST_HELD    = 7'b0010000,
    ST_OLDSCAN = 7'b0100000,
    ST_RETX    = 7'b1000000
  } state_t;

  // Configuration registers
  logic              role_r, role_nxt;
  logic [SEQ_W-1:0]  iseq_r, iseq_nxt;
  logic [WIN_W-1:0]  maxrw_r, maxrw_nxt;
  logic [WIN_W-1:0]  ipw_r, ipw_nxt;
  logic [TICK_W-1:0] tmo_r, tmo_nxt;
  logic [DUP_W-1:0]  dlim_r, dlim_nxt;

  // Connection state
  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [SEQ_W-1:0]  own_r, own_nxt;
  logic [SEQ_W-1:0]  exp_r, exp_nxt;
  logic [SEQ_W-1:0]  hack_r, hack_nxt;
  logic [DUP_W-1:0]  dup_r, dup_nxt;
  logic [WIN_W-1:0]  bif_r, bif_nxt;
  logic [WIN_W-1:0]  pwin_r, pwin_nxt;
  logic [WIN_W-1:0]  bho_r, bho_nxt;
  logic              ackp_r, ackp_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;

  logic [SEND_SLOTS-1:0]    snd_vld_r, snd_vld_nxt;
  logic [REORDER_SLOTS-1:0] ro_vld_r, ro_vld_nxt;

  // Scan control
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rdy_r, rdy_nxt;

  // Latched packet
  logic [SEQ_W-1:0]     pk_seq_r, pk_seq_nxt;
  logic [SEQ_W-1:0]     pk_ack_r, pk_ack_nxt;
  logic [LEN_W-1:0]     pk_len_r, pk_len_nxt;
  logic [RX_SLOT_W-1:0] pk_slot_r, pk_slot_nxt;

  ro_ent_t       dl_r, dl_nxt;
  logic          best_vld_r, best_vld_nxt;
  logic [SW-1:0] best_idx_r, best_idx_nxt;
  snd_ent_t      best_r, best_nxt;

  res_t pr_r, pr_nxt;
  logic pr_vld_r, pr_vld_nxt;
  res_t out_r, out_nxt;
  logic out_vld_r, out_vld_nxt;

  // Memories
  snd_ent_t snd_mem [SEND_SLOTS];
  ro_ent_t  ro_mem [REORDER_SLOTS];
  snd_ent_t snd_rd_r;
  ro_ent_t  ro_rd_r;
  logic     snd_we, ro_we;
  logic [SW-1:0] snd_waddr;
  logic [RW-1:0] ro_waddr;
  snd_ent_t snd_wdata;
  ro_ent_t  ro_wdata;

  logic [SW-1:0] sidx;
  logic [RW-1:0] ridx;
  logic [SW-1:0] snd_free_idx;
  logic [RW-1:0] ro_free_idx;
  logic          snd_free_any, ro_free_any;
  logic [WIN_W-1:0] free_win;
  logic [WIN_W-1:0] room, chunk;
  logic [LEN_W-1:0] cnt;
  logic [TICK_W-1:0] idle_inc;
  logic accept;

  assign sidx     = idx_r[SW-1:0];
  assign ridx     = idx_r[RW-1:0];
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && !pr_vld_r;
  assign free_win = (maxrw_r > bho_r) ? (maxrw_r - bho_r) : '0;
  assign room     = (pwin_r > bif_r) ? (pwin_r - bif_r) : '0;
  assign chunk    = (room < MAX_SEG) ? room : MAX_SEG;
  assign cnt      = ({{(WIN_W-LEN_W){1'b0}}, in_app_bytes} < chunk) ? in_app_bytes
                                                                    : chunk[LEN_W-1:0];
  assign idle_inc = (&idle_r) ? idle_r : idle_r + 1'b1;

  // Find the first free entry of each table
  always_comb begin
    snd_free_idx = '0;
    for (int i = SEND_SLOTS - 1; i >= 0; i--) begin
      if (!snd_vld_r[i]) snd_free_idx = SW'(i);
    end
  end
  assign snd_free_any = ~&snd_vld_r;

  always_comb begin
    ro_free_idx = '0;
    for (int i = REORDER_SLOTS - 1; i >= 0; i--) begin
      if (!ro_vld_r[i]) ro_free_idx = RW'(i);
    end
  end
  assign ro_free_any = ~&ro_vld_r;

  // Next-state logic
  always_comb begin
    role_nxt     = role_r;
    iseq_nxt     = iseq_r;
    maxrw_nxt    = maxrw_r;
    ipw_nxt      = ipw_r;
    tmo_nxt      = tmo_r;
    dlim_nxt     = dlim_r;
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    own_nxt      = own_r;
    exp_nxt      = exp_r;
    hack_nxt     = hack_r;
    dup_nxt      = dup_r;
    bif_nxt      = bif_r;
    pwin_nxt     = pwin_r;
    bho_nxt      = bho_r;
    ackp_nxt     = ackp_r;
    idle_nxt     = idle_r;
    snd_vld_nxt  = snd_vld_r;
    ro_vld_nxt   = ro_vld_r;
    idx_nxt      = idx_r;
    rdy_nxt      = rdy_r;
    pk_seq_nxt   = pk_seq_r;
    pk_ack_nxt   = pk_ack_r;
    pk_len_nxt   = pk_len_r;
    pk_slot_nxt  = pk_slot_r;
    dl_nxt       = dl_r;
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    pr_nxt       = pr_r;
    pr_vld_nxt   = pr_vld_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    snd_we       = 1'b0;
    snd_waddr    = snd_free_idx;
    snd_wdata    = '{seq: own_r, len: cnt};
    ro_we        = 1'b0;
    ro_waddr     = ro_free_idx;
    ro_wdata     = '{seq: pk_seq_r, len: pk_len_r, slot: pk_slot_r};

    // Drain the staging register into the output register
    if (!out_vld_r || out_ready) begin
      out_vld_nxt = pr_vld_r;
      if (pr_vld_r) out_nxt = pr_r;
      pr_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_cmd))
            CMD_PACKET: begin
              unique case (phase_r)
                PH_SERVER_AWAIT: begin
                  if (in_rx_syn && !in_rx_ack_flag) begin
                    exp_nxt   = in_rx_seq + 1'b1;
                    phase_nxt = PH_SERVER_START;
                  end else if (in_rx_ack_flag) begin
                    phase_nxt = PH_NORMAL;
                  end
                end
                PH_CLIENT_AWAIT: begin
                  if (in_rx_syn && in_rx_ack_flag) begin
                    ackp_nxt  = 1'b1;
                    exp_nxt   = in_rx_seq + 1'b1;
                    own_nxt   = own_r + 1'b1;
                    phase_nxt = PH_NORMAL;
                  end
                end
                PH_NORMAL: begin
                  pwin_nxt    = in_rx_window;
                  pk_seq_nxt  = in_rx_seq;
                  pk_ack_nxt  = in_rx_ack;
                  pk_len_nxt  = in_rx_length;
                  pk_slot_nxt = in_rx_slot;
                  idx_nxt     = '0;
                  rdy_nxt     = 1'b0;
                  if (in_rx_ack_flag && (in_rx_ack > hack_r)) begin
                    hack_nxt  = in_rx_ack;
                    dup_nxt   = '0;
                    state_nxt = ST_ACKSCAN;
                  end else begin
                    if (in_rx_ack_flag && (in_rx_ack == hack_r) && (hack_r != '0)
                        && !(&dup_r)) begin
                      dup_nxt = dup_r + 1'b1;
                    end
                    state_nxt = ST_PAYLOAD;
                  end
                end
                default: ;
              endcase
            end
            CMD_POLL: begin
              unique case (phase_r)
                PH_CLIENT_START: begin
                  pr_nxt = mk_res(KIND_SYN, own_r, '0, 1'b1, 1'b0, '0, maxrw_r, '0, 1'b1);
                  pr_vld_nxt = 1'b1;
                  phase_nxt  = PH_CLIENT_AWAIT;
                  idle_nxt   = '0;
                end
                PH_SERVER_START: begin
                  pr_nxt = mk_res(KIND_SYNACK, own_r, exp_r, 1'b1, 1'b1, '0, maxrw_r, '0,
                                  1'b1);
                  pr_vld_nxt = 1'b1;
                  own_nxt    = own_r + 1'b1;
                  phase_nxt  = PH_SERVER_AWAIT;
                  idle_nxt   = '0;
                end
                PH_NORMAL: begin
                  if (ackp_r) begin
                    pr_nxt = mk_res(KIND_ACK, own_r, exp_r, 1'b0, 1'b1, '0, free_win, '0,
                                    1'b1);
                    pr_vld_nxt = 1'b1;
                    ackp_nxt   = 1'b0;
                    idle_nxt   = '0;
                  end else if ((cnt != '0) && snd_free_any) begin
                    snd_we = 1'b1;
                    snd_vld_nxt[snd_free_idx] = 1'b1;
                    pr_nxt = mk_res(KIND_DATA, own_r, exp_r, 1'b0, 1'b1, cnt, free_win,
                                    SLOT_W'(snd_free_idx), 1'b1);
                    pr_vld_nxt = 1'b1;
                    bif_nxt    = bif_r + {{(WIN_W-LEN_W){1'b0}}, cnt};
                    own_nxt    = own_r + 1'b1;
                    idle_nxt   = '0;
                  end
                end
                default: ;
              endcase
            end
            CMD_TICK: begin
              idx_nxt      = '0;
              rdy_nxt      = 1'b0;
              best_vld_nxt = 1'b0;
              if (!(|snd_vld_r)) begin
                idle_nxt = '0;
              end else if (idle_inc >= tmo_r) begin
                idle_nxt  = '0;
                state_nxt = ST_OLDSCAN;
              end else if (dup_r >= dlim_r) begin
                idle_nxt  = '0;
                dup_nxt   = '0;
                state_nxt = ST_OLDSCAN;
              end else begin
                idle_nxt = idle_inc;
              end
            end
            default: ;
          endcase
        end
      end

      // Free every outstanding segment below the new ACK
      ST_ACKSCAN: begin
        if (!rdy_r) begin
          rdy_nxt = 1'b1;
        end else begin
          if (snd_vld_r[sidx] && (snd_rd_r.seq < pk_ack_r)) begin
            bif_nxt = (bif_r > {{(WIN_W-LEN_W){1'b0}}, snd_rd_r.len})
                      ? bif_r - {{(WIN_W-LEN_W){1'b0}}, snd_rd_r.len} : '0;
            snd_vld_nxt[sidx] = 1'b0;
          end
          rdy_nxt = 1'b0;
          if (idx_r == SEND_LAST) begin
            idx_nxt   = '0;
            state_nxt = ST_PAYLOAD;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_PAYLOAD: begin
        if (pk_len_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          ackp_nxt = 1'b1;
          if (pk_seq_r == exp_r) begin
            dl_nxt    = '{seq: pk_seq_r, len: pk_len_r, slot: pk_slot_r};
            exp_nxt   = exp_r + 1'b1;
            state_nxt = ST_ROSCAN;
          end else if (pk_seq_r > exp_r) begin
            state_nxt = ST_HELD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      // Release held segments that continue the in-order run
      ST_ROSCAN: begin
        if (!rdy_r) begin
          rdy_nxt = 1'b1;
        end else if (ro_vld_r[ridx] && (ro_rd_r.seq == exp_r)) begin
          if (!pr_vld_r) begin
            pr_nxt = mk_res(KIND_DELIVER, dl_r.seq, '0, 1'b0, 1'b0, dl_r.len, '0,
                            SLOT_W'(dl_r.slot), 1'b0);
            pr_vld_nxt = 1'b1;
            dl_nxt     = ro_rd_r;
            exp_nxt    = exp_r + 1'b1;
            bho_nxt    = (bho_r > {{(WIN_W-LEN_W){1'b0}}, ro_rd_r.len})
                         ? bho_r - {{(WIN_W-LEN_W){1'b0}}, ro_rd_r.len} : '0;
            ro_vld_nxt[ridx] = 1'b0;
            idx_nxt = '0;
            rdy_nxt = 1'b0;
          end
        end else if (idx_r == RO_LAST) begin
          if (!pr_vld_r) begin
            pr_nxt = mk_res(KIND_DELIVER, dl_r.seq, '0, 1'b0, 1'b0, dl_r.len, '0,
                            SLOT_W'(dl_r.slot), 1'b1);
            pr_vld_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          rdy_nxt = 1'b0;
        end
      end

      // Hold an early segment unless it is a duplicate or the table is full
      ST_HELD: begin
        if (!rdy_r) begin
          rdy_nxt = 1'b1;
        end else if ((ro_vld_r[ridx] && (ro_rd_r.seq == pk_seq_r))
                     || ((idx_r == RO_LAST) && !ro_free_any)) begin
          if (!pr_vld_r) begin
            pr_nxt = mk_res(KIND_DROP, pk_seq_r, '0, 1'b0, 1'b0, pk_len_r, '0,
                            SLOT_W'(pk_slot_r), 1'b1);
            pr_vld_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else if (idx_r == RO_LAST) begin
          ro_we = 1'b1;
          ro_vld_nxt[ro_free_idx] = 1'b1;
          bho_nxt   = bho_r + {{(WIN_W-LEN_W){1'b0}}, pk_len_r};
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rdy_nxt = 1'b0;
        end
      end

      // Find the outstanding segment with the smallest sequence
      ST_OLDSCAN: begin
        if (!rdy_r) begin
          rdy_nxt = 1'b1;
        end else begin
          if (snd_vld_r[sidx] && (!best_vld_r || (snd_rd_r.seq < best_r.seq))) begin
            best_vld_nxt = 1'b1;
            best_idx_nxt = sidx;
            best_nxt     = snd_rd_r;
          end
          rdy_nxt = 1'b0;
          if (idx_r == SEND_LAST) begin
            state_nxt = ST_RETX;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_RETX: begin
        if (!pr_vld_r) begin
          pr_nxt = mk_res(KIND_RETX, best_r.seq, exp_r, 1'b0, 1'b1, best_r.len, free_win,
                          SLOT_W'(best_idx_r), 1'b1);
          pr_vld_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Register writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_ROLE: begin
          role_nxt  = cfg_data[0];
          phase_nxt = cfg_data[0] ? PH_SERVER_AWAIT : PH_CLIENT_START;
        end
        CFG_INIT_SEQ: begin
          iseq_nxt = cfg_data[SEQ_W-1:0];
          own_nxt  = cfg_data[SEQ_W-1:0];
        end
        CFG_MAX_RWIN: maxrw_nxt = cfg_data[WIN_W-1:0];
        CFG_PEER_WIN: begin
          ipw_nxt  = cfg_data[WIN_W-1:0];
          pwin_nxt = cfg_data[WIN_W-1:0];
        end
        CFG_TIMEOUT:   tmo_nxt  = cfg_data[TICK_W-1:0];
        CFG_DUP_LIMIT: dlim_nxt = cfg_data[DUP_W-1:0];
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r     <= RST_START_ROLE;
      iseq_r     <= RST_INIT_SEQ;
      maxrw_r    <= RST_MAX_RWIN;
      ipw_r      <= RST_PEER_WIN;
      tmo_r      <= RST_TIMEOUT;
      dlim_r     <= RST_DUP_LIMIT;
      state_r    <= ST_IDLE;
      phase_r    <= RST_START_ROLE ? PH_SERVER_AWAIT : PH_CLIENT_START;
      own_r      <= RST_INIT_SEQ;
      exp_r      <= '0;
      hack_r     <= '0;
      dup_r      <= '0;
      bif_r      <= '0;
      pwin_r     <= RST_PEER_WIN;
      bho_r      <= '0;
      ackp_r     <= 1'b0;
      idle_r     <= '0;
      snd_vld_r  <= '0;
      ro_vld_r   <= '0;
      idx_r      <= '0;
      rdy_r      <= 1'b0;
      best_vld_r <= 1'b0;
      pr_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      role_r     <= role_nxt;
      iseq_r     <= iseq_nxt;
      maxrw_r    <= maxrw_nxt;
      ipw_r      <= ipw_nxt;
      tmo_r      <= tmo_nxt;
      dlim_r     <= dlim_nxt;
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      own_r      <= own_nxt;
      exp_r      <= exp_nxt;
      hack_r     <= hack_nxt;
      dup_r      <= dup_nxt;
      bif_r      <= bif_nxt;
      pwin_r     <= pwin_nxt;
      bho_r      <= bho_nxt;
      ackp_r     <= ackp_nxt;
      idle_r     <= idle_nxt;
      snd_vld_r  <= snd_vld_nxt;
      ro_vld_r   <= ro_vld_nxt;
      idx_r      <= idx_nxt;
      rdy_r      <= rdy_nxt;
      best_vld_r <= best_vld_nxt;
      pr_vld_r   <= pr_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pk_seq_r   <= pk_seq_nxt;
    pk_ack_r   <= pk_ack_nxt;
    pk_len_r   <= pk_len_nxt;
    pk_slot_r  <= pk_slot_nxt;
    dl_r       <= dl_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    pr_r       <= pr_nxt;
    out_r      <= out_nxt;
  end

  // Send table memory
  always_ff @(posedge clk) begin
    if (snd_we) snd_mem[snd_waddr] <= snd_wdata;
    snd_rd_r <= snd_mem[sidx];
  end

  // Reorder table memory
  always_ff @(posedge clk) begin
    if (ro_we) ro_mem[ro_waddr] <= ro_wdata;
    ro_rd_r <= ro_mem[ridx];
  end

  assign out_valid    = out_vld_r;
  assign out_kind     = out_r.kind;
  assign out_seq      = out_r.seq;
  assign out_ack      = out_r.ack;
  assign out_syn      = out_r.syn;
  assign out_ack_flag = out_r.ack_flag;
  assign out_length   = out_r.len;
  assign out_window   = out_r.win;
  assign out_slot     = out_r.slot;
  assign out_last     = out_r.last;

endmodule

`default_nettype wire

/* hw/rtl/swtc_checker.sv */
`default_nettype none

module swtc_checker
  import swtc_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] out_kind,
  input wire       out_syn,
  input wire       out_ack_flag,
  input wire       out_last
);

  // Stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("result item changed while stalled");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Handshake segments are single results carrying SYN
  a_syn_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SYN || out_kind == KIND_SYNACK) |-> out_syn && out_last)
    else $error("handshake result malformed");

  // Deliver and dropped results carry no header flags
  a_deliver_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DELIVER || out_kind == KIND_DROP)
    |-> !out_syn && !out_ack_flag)
    else $error("deliver result carries flags");

endmodule

bind sliding_window_transport_control swtc_checker u_swtc_checker (.*);

`default_nettype wire
